@@ hw/rtl/rsrb_pkg.sv @@
package rsrb_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned ST_W   = 3;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;  // packet_seq, rx_ok, wanted_seq
  localparam int unsigned M_TDATA_W = 24;  // slot, seq_out

  typedef enum logic [ST_W-1:0] {
    ST_STORED = 3'd0,
    ST_FULL   = 3'd1,
    ST_RXERR  = 3'd2,
    ST_HIT    = 3'd3,
    ST_SEARCH = 3'd4,
    ST_MISS   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCAN,
    S_EMIT
  } state_e;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Advance a ring pointer; an unset pointer moves to slot 0.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                 input logic             vld);
    logic [IDX_W-1:0] res;
    if (!vld) begin
      res = '0;
    end else if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/rtp_sequence_ring_buffer.sv @@
// RTP sequence ring buffer.
//
// Tracks the RTP sequence number held in each of DEPTH packet slots.
// Slave stream: tuser = kind (0 packet arrival, 1 read request); tdata carries
// packet_seq, rx_ok and wanted_seq. Master stream: tuser = status, tdata
// carries slot and seq_out. Every input transaction yields exactly one output
// transaction. cfg_we_i writes master_mode (1 = refuse arrivals when full,
// 0 = overwrite the oldest entry); write it only while the block is idle.
//
// One transaction is worked on at a time; after the accept it passes through:
//   arrival                  : S_EXEC, S_EMIT
//   read, in-order hit       : S_EXEC, S_CHECK, S_EMIT
//   read, search hit or miss : S_EXEC, S_CHECK, S_SCAN, S_EMIT
// S_SCAN reads slot 0 up to the hit slot, or all DEPTH slots on a miss, one slot per
// cycle, set by the single read port of the sequence RAM. tready rises with output valid.
//
// Reset clears both pointers to "before first slot", all slot valid bits and
// master_mode. The RAM itself is never cleared: the valid flops mask it.
// A stalled receiver holds the result in the output register; one more
// transaction may be accepted and worked on, and then waits for that slot.
module rtp_sequence_ring_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,     // master_mode
  // slave stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rsrb_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // [15:0] packet_seq,
                                                          // [16] rx_ok,
                                                          // [32:17] wanted_seq
  input  logic                           s_axis_tuser_i,  // [0] kind
  // master stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rsrb_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // [5:0] slot,
                                                          // [21:6] seq_out
  output logic [rsrb_pkg::ST_W-1:0]      m_axis_tuser_o   // [2:0] status
);

  localparam int unsigned IDX_W = rsrb_pkg::IDX_W;
  localparam int unsigned SEQ_W = rsrb_pkg::SEQ_W;

  rsrb_pkg::state_e state_q, state_d;

  // ring pointers
  logic [IDX_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic             wp_vld_q, wp_vld_d, rp_vld_q, rp_vld_d;
  logic [rsrb_pkg::DEPTH-1:0] vld_q, vld_d;
  logic             master_q;

  // captured transaction
  logic             kind_q;
  logic [SEQ_W-1:0] pseq_q, want_q;
  logic             ok_q;

  // scan index: slot whose RAM data is on rdata this cycle
  logic [IDX_W-1:0] chk_q, chk_d;

  // pending result
  rsrb_pkg::status_e res_status_q, res_status_d;
  logic [IDX_W-1:0]  res_slot_q, res_slot_d;
  logic [SEQ_W-1:0]  res_seq_q, res_seq_d;

  // output register
  logic              out_vld_q, out_vld_d;
  rsrb_pkg::status_e out_status_q;
  logic [IDX_W-1:0]  out_slot_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic              out_load;

  // RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [SEQ_W-1:0] ram_rdata;

  // arrival helpers
  logic [IDX_W-1:0] wr_slot;
  logic [IDX_W-1:0] rp_eff;
  logic             rp_eff_vld, ring_full;
  logic             s_accept;
  logic             match;

  assign s_axis_tready_o = (state_q == rsrb_pkg::S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == rsrb_pkg::S_EMIT) && (!out_vld_q || m_axis_tready_i);

  // Arrival: the read pointer snaps to slot 0 once the write side leaves it.
  assign wr_slot    = rsrb_pkg::next_slot(wp_q, wp_vld_q);
  assign rp_eff_vld = rp_vld_q || (wr_slot != '0);
  assign rp_eff     = rp_vld_q ? rp_q : '0;
  assign ring_full  = rp_eff_vld && (wr_slot == rp_eff);

  // RAM data against the wanted sequence, gated by the slot's valid bit
  assign match = (ram_rdata == want_q) && vld_q[chk_q];

  rsrb_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (rsrb_pkg::DEPTH)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (pseq_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    wp_vld_d     = wp_vld_q;
    rp_d         = rp_q;
    rp_vld_d     = rp_vld_q;
    vld_d        = vld_q;
    chk_d        = chk_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_seq_d    = res_seq_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_slot;
    ram_raddr    = '0;

    unique case (state_q)
      rsrb_pkg::S_IDLE: begin
        if (s_accept) begin
          state_d = rsrb_pkg::S_EXEC;
        end
      end

      rsrb_pkg::S_EXEC: begin
        if (kind_q == rsrb_pkg::KIND_ARRIVAL) begin
          if (!rp_vld_q && (wr_slot != '0)) begin
            rp_d     = '0;
            rp_vld_d = 1'b1;
          end
          if (ring_full && master_q) begin
            res_status_d = rsrb_pkg::ST_FULL;
            res_slot_d   = '0;
            res_seq_d    = '0;
          end else begin
            if (ring_full) begin
              // drop the oldest entry
              rp_d     = rsrb_pkg::next_slot(wr_slot, 1'b1);
              rp_vld_d = 1'b1;
            end
            wp_d           = wr_slot;
            wp_vld_d       = 1'b1;
            ram_we         = ok_q;
            vld_d[wr_slot] = ok_q;
            res_slot_d     = wr_slot;
            if (ok_q) begin
              res_status_d = rsrb_pkg::ST_STORED;
              res_seq_d    = pseq_q;
            end else begin
              res_status_d = rsrb_pkg::ST_RXERR;
              res_seq_d    = '0;
            end
          end
          state_d = rsrb_pkg::S_EMIT;
        end else begin
          // read: step the read pointer and fetch that slot
          rp_d      = rsrb_pkg::next_slot(rp_q, rp_vld_q);
          rp_vld_d  = 1'b1;
          ram_raddr = rp_d;
          chk_d     = rp_d;
          state_d   = rsrb_pkg::S_CHECK;
        end
      end

      rsrb_pkg::S_CHECK: begin
        if (match) begin
          vld_d[chk_q] = 1'b0;
          res_status_d = rsrb_pkg::ST_HIT;
          res_slot_d   = chk_q;
          res_seq_d    = want_q;
          state_d      = rsrb_pkg::S_EMIT;
        end else begin
          ram_raddr = '0;
          chk_d     = '0;
          state_d   = rsrb_pkg::S_SCAN;
        end
      end

      rsrb_pkg::S_SCAN: begin
        // one slot per cycle, lowest first
        ram_raddr = chk_q + IDX_W'(1);
        chk_d     = chk_q + IDX_W'(1);
        if (match) begin
          rp_d         = chk_q;
          res_status_d = rsrb_pkg::ST_SEARCH;
          res_slot_d   = chk_q;
          res_seq_d    = want_q;
          state_d      = rsrb_pkg::S_EMIT;
        end else if (chk_q == IDX_W'(rsrb_pkg::DEPTH - 1)) begin
          res_status_d = rsrb_pkg::ST_MISS;
          res_slot_d   = '0;
          res_seq_d    = '0;
          state_d      = rsrb_pkg::S_EMIT;
        end
      end

      rsrb_pkg::S_EMIT: begin
        if (out_load) begin
          state_d = rsrb_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rsrb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsrb_pkg::S_IDLE;
      wp_q      <= '0;
      wp_vld_q  <= 1'b0;
      rp_q      <= '0;
      rp_vld_q  <= 1'b0;
      vld_q     <= '0;
      master_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      wp_vld_q  <= wp_vld_d;
      rp_q      <= rp_d;
      rp_vld_q  <= rp_vld_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        master_q <= cfg_wdata_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q <= s_axis_tuser_i;
      pseq_q <= s_axis_tdata_i[SEQ_W-1:0];
      ok_q   <= s_axis_tdata_i[SEQ_W];
      want_q <= s_axis_tdata_i[2*SEQ_W:SEQ_W+1];
    end
    chk_q        <= chk_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_seq_q    <= res_seq_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_seq_q    <= res_seq_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {
    (rsrb_pkg::M_TDATA_W - rsrb_pkg::SLOT_W - SEQ_W)'(0),
    out_seq_q,
    rsrb_pkg::SLOT_W'(out_slot_q)
  };

endmodule

@@ hw/rtl/rsrb_ram.sv @@
module rsrb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rsrb_chk.sv @@
module rsrb_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic                           cfg_wdata_i,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [rsrb_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                           s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [rsrb_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [rsrb_pkg::ST_W-1:0]      m_axis_tuser_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output transaction changed");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("second transaction accepted while busy");

  // status code in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= rsrb_pkg::ST_MISS))
    else $error("status code out of range");

  // refusal and miss carry no slot or sequence
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == rsrb_pkg::ST_FULL ||
                        m_axis_tuser_o == rsrb_pkg::ST_MISS)
      |-> (m_axis_tdata_o == '0))
    else $error("refused or missed transaction has nonzero payload");

  // no result appears the cycle right after an accept
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("output appeared too early");

endmodule

bind rtp_sequence_ring_buffer rsrb_chk u_rsrb_chk (.*);
